FILE: rtl/core/signed_integer_to_radix_text_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix text converter
// Implication checks, same cycle and next cycle, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`ifndef SYNTHESIS
`define SITR_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sitr: same-cycle check failed");
`define SITR_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sitr: next-cycle check failed");
`else
`define SITR_ASSERT_IMP(label, ck, rn, ante, cons)
`define SITR_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

FILE: rtl/core/sitr_pkg.sv
// ----------------------------------------------------------------------------
// sitr_pkg
// Shared constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package sitr_pkg;

  localparam int NUMBER_BITS_DEF = 32;
  localparam int MAX_RADIX       = 32;
  localparam int MIN_RADIX       = 2;
  localparam int ALPHA_CHARS     = 32;
  localparam int CHAR_W          = 8;
  localparam int WORD_W          = 64;
  localparam int CHARS_PER_WORD  = WORD_W / CHAR_W;
  localparam int LEN_W           = 6;
  localparam int DIG_W           = 5;
  localparam int DIV_BITS        = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_BASE_LEN = 3'd0;
  localparam cfg_idx_t REG_ALPHA0   = 3'd1;
  localparam cfg_idx_t REG_ALPHA1   = 3'd2;
  localparam cfg_idx_t REG_ALPHA2   = 3'd3;
  localparam cfg_idx_t REG_ALPHA3   = 3'd4;

  localparam logic [LEN_W-1:0]  BASE_LEN_RST = 6'd10;
  localparam logic [WORD_W-1:0] ALPHA0_RST   = 64'd3978425819141910832;
  localparam logic [WORD_W-1:0] ALPHA1_RST   = 64'd14648;
  localparam logic [WORD_W-1:0] ALPHA2_RST   = 64'd0;
  localparam logic [WORD_W-1:0] ALPHA3_RST   = 64'd0;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef logic [ALPHA_CHARS-1:0][CHAR_W-1:0] alpha_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_DIV,
    ST_PUSH,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef enum logic [1:0] {
    OUT_SIGN,
    OUT_DIGIT,
    OUT_ERR
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     chk_init;
    logic     chk_step;
    logic     div_step;
    logic     push;
    logic     rd;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic known;
    logic ok;
    logic chk_end;
    logic div_last;
    logic push_done;
    logic neg;
    logic nd_zero;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sitr_ram.sv
// ----------------------------------------------------------------------------
// sitr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sitr_ram #(
  parameter int WIDTH = sitr_pkg::DIG_W,
  parameter int DEPTH = sitr_pkg::NUMBER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sitr_ctrl.sv
// ----------------------------------------------------------------------------
// sitr_ctrl
// Sequencer: alphabet check, digit division, sign and digit emission, error result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_integer_to_radix_text_assert.svh"

module sitr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sitr_pkg::dp_sts_t sts,
  output sitr_pkg::dp_cmd_t cmd
);

  import sitr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (sts.known) begin
          state_nxt = sts.ok ? ST_DIV : ST_ERR;
        end else begin
          cmd.chk_init = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.chk_step = 1'b1;
        if (sts.chk_end) begin
          state_nxt = ST_START;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (sts.push_done) begin
          state_nxt = sts.neg ? ST_SIGN : ST_READ;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_SIGN;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_DIGIT;
          state_nxt    = sts.nd_zero ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_ERR;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SITR_ASSERT_NXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == ST_START)
  `SITR_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)
  `SITR_ASSERT_IMP(a_single_op, clk, rst_n, 1'b1,
                   $onehot0({cmd.load, cmd.chk_step, cmd.div_step,
                             cmd.push, cmd.rd, cmd.out_load}))

endmodule

`default_nettype wire

FILE: rtl/core/sitr_dp.sv
// ----------------------------------------------------------------------------
// sitr_dp
// Config registers, alphabet checker, 4-bit-per-cycle divider, digit stack
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sitr_dp #(
  parameter int NUMBER_BITS = sitr_pkg::NUMBER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  sitr_pkg::cfg_idx_t              cfg_index,
  input  logic [sitr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [NUMBER_BITS-1:0]          in_number,
  input  sitr_pkg::dp_cmd_t               cmd,
  output sitr_pkg::dp_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sitr_pkg::CHAR_W-1:0]     out_char,
  output logic                            out_last,
  output logic                            out_bad
);

  import sitr_pkg::*;

  localparam int DIV_W     = ((NUMBER_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int ND_W      = $clog2(NUMBER_BITS + 1);
  localparam int AW        = $clog2(NUMBER_BITS);

  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  alpha_t            alpha_r;
  alpha_t            alpha_nxt;
  logic              known_r;
  logic              known_nxt;
  logic              ok_r;
  logic              ok_nxt;
  logic [DIG_W-1:0]  idx_r;
  logic [DIG_W-1:0]  idx_nxt;
  logic              neg_r;
  logic              neg_nxt;
  logic [DIV_W-1:0]  quo_r;
  logic [DIV_W-1:0]  quo_nxt;
  logic [DIG_W-1:0]  rem_r;
  logic [DIG_W-1:0]  rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [ND_W-1:0]   nd_r;
  logic [ND_W-1:0]   nd_nxt;
  logic [ND_W-1:0]   nd_m1;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic [CHAR_W-1:0] out_char_nxt;
  logic              out_last_r;
  logic              out_last_nxt;
  logic              out_bad_r;
  logic              out_bad_nxt;

  logic                   len_ok;
  logic                   pos_bad;
  logic                   chk_end;
  logic [DIV_W-1:0]       div_q;
  logic [DIG_W-1:0]       div_r;
  logic [NUMBER_BITS-1:0] mag;
  logic [DIG_W-1:0]       dig_rd;
  logic                   out_free;

  // alphabet position check: sign characters and repeats further up
  always_comb begin
    logic [CHAR_W-1:0] c;
    logic              dup;
    c   = alpha_r[idx_r];
    dup = 1'b0;
    for (int j = 0; j < ALPHA_CHARS; j++) begin
      if ((DIG_W'(j) > idx_r) && (LEN_W'(j) < len_r) && (alpha_r[j] == c)) begin
        dup = 1'b1;
      end
    end
    pos_bad = dup || (c == CHAR_PLUS) || (c == CHAR_MINUS);
  end

  assign len_ok  = (int'(len_r) >= MIN_RADIX) && (int'(len_r) <= MAX_RADIX) &&
                   (int'(len_r) <= ALPHA_CHARS);
  assign chk_end = !len_ok || ({1'b0, idx_r} == (len_r - LEN_W'(1)));

  // four restoring division steps on the running remainder
  always_comb begin
    logic [DIG_W:0] t;
    logic           ge;
    div_q = quo_r;
    div_r = rem_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      t     = {div_r, div_q[DIV_W-1]};
      ge    = (t >= len_r);
      div_q = {div_q[DIV_W-2:0], ge};
      if (ge) begin
        t = t - len_r;
      end
      div_r = t[DIG_W-1:0];
    end
  end

  assign mag      = in_number[NUMBER_BITS-1] ? (~in_number + NUMBER_BITS'(1)) : in_number;
  assign nd_m1    = nd_r - ND_W'(1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    len_nxt       = len_r;
    alpha_nxt     = alpha_r;
    known_nxt     = known_r;
    ok_nxt        = ok_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    nd_nxt        = nd_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;

    if (cfg_we) begin
      known_nxt = 1'b0;
      unique case (cfg_index)
        REG_BASE_LEN: len_nxt = cfg_wdata[LEN_W-1:0];
        REG_ALPHA0:   alpha_nxt[0*CHARS_PER_WORD +: CHARS_PER_WORD] = cfg_wdata;
        REG_ALPHA1:   alpha_nxt[1*CHARS_PER_WORD +: CHARS_PER_WORD] = cfg_wdata;
        REG_ALPHA2:   alpha_nxt[2*CHARS_PER_WORD +: CHARS_PER_WORD] = cfg_wdata;
        REG_ALPHA3:   alpha_nxt[3*CHARS_PER_WORD +: CHARS_PER_WORD] = cfg_wdata;
        default: ;
      endcase
    end else if (cmd.chk_step && chk_end) begin
      known_nxt = 1'b1;
    end

    if (cmd.chk_init) begin
      ok_nxt  = len_ok;
      idx_nxt = '0;
    end else if (cmd.chk_step) begin
      if (pos_bad) begin
        ok_nxt = 1'b0;
      end
      idx_nxt = idx_r + DIG_W'(1);
    end

    if (cmd.load) begin
      neg_nxt = in_number[NUMBER_BITS-1];
      quo_nxt = DIV_W'(mag);
      rem_nxt = '0;
      cnt_nxt = '0;
      nd_nxt  = '0;
    end else if (cmd.div_step) begin
      quo_nxt = div_q;
      rem_nxt = div_r;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.push) begin
      rem_nxt = '0;
      cnt_nxt = '0;
      nd_nxt  = nd_r + ND_W'(1);
    end else if (cmd.rd) begin
      nd_nxt = nd_m1;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      unique case (cmd.out_sel)
        OUT_SIGN: begin
          out_char_nxt = CHAR_MINUS;
          out_last_nxt = 1'b0;
          out_bad_nxt  = 1'b0;
        end
        OUT_DIGIT: begin
          out_char_nxt = alpha_r[dig_rd];
          out_last_nxt = (nd_r == '0);
          out_bad_nxt  = 1'b0;
        end
        default: begin
          out_char_nxt = CHAR_NUL;
          out_last_nxt = 1'b1;
          out_bad_nxt  = 1'b1;
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= BASE_LEN_RST;
      alpha_r     <= {ALPHA3_RST, ALPHA2_RST, ALPHA1_RST, ALPHA0_RST};
      known_r     <= 1'b0;
      ok_r        <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      nd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      alpha_r     <= alpha_nxt;
      known_r     <= known_nxt;
      ok_r        <= ok_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      nd_r        <= nd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  sitr_ram #(
    .WIDTH (DIG_W),
    .DEPTH (NUMBER_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (nd_r[AW-1:0]),
    .wdata (rem_r),
    .re    (cmd.rd),
    .raddr (nd_m1[AW-1:0]),
    .rdata (dig_rd)
  );

  always_comb begin
    sts           = '0;
    sts.known     = known_r;
    sts.ok        = ok_r;
    sts.chk_end   = chk_end;
    sts.div_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));
    sts.push_done = (quo_r == '0) || (nd_r == ND_W'(NUMBER_BITS - 1));
    sts.neg       = neg_r;
    sts.nd_zero   = (nd_r == '0);
    sts.out_free  = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_bad   = out_bad_r;

endmodule

`default_nettype wire

FILE: rtl/core/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a signed number to text in a configured radix and digit alphabet,
// one character per output transaction, most significant digit first.
// ----------------------------------------------------------------------------
//
//  Channel  Ports     Payload (low bit up)                       Role
//  -------  --------  -----------------------------------------  -------------
//  in       in_t*     tdata: number                              number to print
//  out      out_t*    tdata: character, tlast: last, tuser: bad  one char each
//  cfg      cfg_*     index 0 base_length, 1..4 alphabet words   register write
//
//  One number at a time. The first number after any cfg write adds an
//  alphabet check whose result is then kept; the check fails outright when
//  base_length is below 2 or above 32. A bad alphabet gives one error
//  transaction.
//  Reset is synchronous; out backpressure stalls emission only.
//
`default_nettype none

module signed_integer_to_radix_text #(
  parameter int NUMBER_BITS = sitr_pkg::NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((NUMBER_BITS+7)/8)*8-1:0]    in_tdata,    // number
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sitr_pkg::CHAR_W-1:0]         out_tdata,   // character
  output logic                                out_tlast,
  output logic                                out_tuser,   // base_invalid
  input  logic                                cfg_we,
  input  logic [sitr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sitr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import sitr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sitr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sitr_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_number (in_tdata[NUMBER_BITS-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_bad   (out_tuser)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for signed_integer_to_radix_text
// Streams signed numbers into the converter under a series of radix and
// alphabet settings. Every accepted number is turned into its expected
// characters by a scoreboard model, and each output transaction is compared
// with the oldest expected character. Both channels idle at random.
// ----------------------------------------------------------------------------

module testbench;
  import sitr_pkg::*;

  localparam int NUMBER_W = NUMBER_BITS_DEF;
  localparam int IN_W = ((NUMBER_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 19;
  localparam cfg_idx_t REG_UNUSED_LO = REG_ALPHA3 + 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              bad;
  } text_char_t;

  typedef enum int {FLAW_NONE, FLAW_PLUS, FLAW_MINUS, FLAW_REPEAT} alpha_flaw_t;

  class radix_text_scoreboard;
    logic [LEN_W-1:0] radix_len;
    alpha_t           digit_set;
    text_char_t       expected_chars[$];
    int unsigned      mismatches;
    int unsigned      numbers_seen;
    int unsigned      chars_seen;
    int unsigned      errors_seen;

    function new();
      radix_len = BASE_LEN_RST;
      digit_set = {ALPHA3_RST, ALPHA2_RST, ALPHA1_RST, ALPHA0_RST};
      mismatches = 0;
      numbers_seen = 0;
      chars_seen = 0;
      errors_seen = 0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      int unsigned w;
      case (idx)
        REG_BASE_LEN: begin
          radix_len = data[LEN_W-1:0];
        end
        REG_ALPHA0, REG_ALPHA1, REG_ALPHA2, REG_ALPHA3: begin
          w = int'(idx - REG_ALPHA0);
          for (int k = 0; k < CHARS_PER_WORD; k++)
            digit_set[w * CHARS_PER_WORD + k] = data[k * CHAR_W +: CHAR_W];
        end
        default: ;
      endcase
    endfunction

    function bit alphabet_usable();
      int len;
      len = int'(radix_len);
      if (len < MIN_RADIX || len > MAX_RADIX || len > ALPHA_CHARS)
        return 1'b0;
      for (int i = 0; i < len; i++) begin
        if (digit_set[i] == CHAR_PLUS || digit_set[i] == CHAR_MINUS)
          return 1'b0;
        for (int j = i + 1; j < len; j++)
          if (digit_set[j] == digit_set[i])
            return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [NUMBER_W-1:0] number);
      logic [NUMBER_W-1:0] mag;
      int unsigned         radix;
      int unsigned         digit_buf[NUMBER_W];
      int                  nd;
      numbers_seen++;
      if (!alphabet_usable()) begin
        expected_chars.push_back('{ch: CHAR_NUL, last: 1'b1, bad: 1'b1});
        return;
      end
      radix = int'(radix_len);
      mag = number[NUMBER_W-1] ? (~number + 1'b1) : number;
      nd = 0;
      do begin
        digit_buf[nd] = int'(mag % radix);
        mag = mag / radix;
        nd++;
      end while (mag != 0 && nd < NUMBER_W);
      if (number[NUMBER_W-1])
        expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
      for (int i = nd - 1; i >= 0; i--)
        expected_chars.push_back('{ch: digit_set[digit_buf[i]], last: (i == 0), bad: 1'b0});
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last, logic bad);
      text_char_t want;
      chars_seen++;
      if (bad)
        errors_seen++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected transaction char=%h last=%b bad=%b", $time, ch, last, bad);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: character expected %h actual %h", $time, want.ch, ch);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        mismatches++;
      end
      if (bad !== want.bad) begin
        $display("%0t: base_invalid expected %b actual %b", $time, want.bad, bad);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [CHAR_W-1:0]      out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  radix_text_scoreboard sb;
  bit          gaps_on = 1'b1;
  int unsigned settings_applied = 0;
  int unsigned quiet_cycles = 0;

  signed_integer_to_radix_text DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // number
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // character
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),   // base_invalid
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: stall at random, check every transaction
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      sb.check_char(out_tdata, out_tlast, out_tuser);
    end
  end

  task automatic send_number(input logic [NUMBER_W-1:0] number);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(number);
    do @(posedge clk); while (!in_tready);
    sb.note_number(number);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_register(idx, data);
  endtask

  task automatic apply_config(input int len, input alpha_t digits, input bit poke_unused);
    logic [ALPHA_CHARS*CHAR_W-1:0] flat;
    cfg_idx_t                      spare;
    flat = digits;
    write_reg(REG_BASE_LEN, CFG_DATA_W'(len));
    for (int w = 0; w < ALPHA_CHARS / CHARS_PER_WORD; w++)
      write_reg(cfg_idx_t'(REG_ALPHA0 + w), flat[w * WORD_W +: WORD_W]);
    if (poke_unused) begin
      spare = cfg_idx_t'($urandom_range(int'(REG_UNUSED_LO), (1 << CFG_IDX_W) - 1));
      write_reg(spare, {$urandom, $urandom});
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  function automatic alpha_t build_alphabet(int len, alpha_flaw_t flaw, bit lead_nul);
    alpha_t       digits;
    bit           taken[256];
    logic [7:0]   pick;
    int           first;
    int           span;
    int           i;
    int           j;
    foreach (taken[k])
      taken[k] = 1'b0;
    taken[CHAR_PLUS] = 1'b1;
    taken[CHAR_MINUS] = 1'b1;
    span = (len < ALPHA_CHARS) ? len : ALPHA_CHARS;
    first = 0;
    if (lead_nul) begin
      digits[0] = CHAR_NUL;
      taken[CHAR_NUL] = 1'b1;
      first = 1;
    end
    for (int k = first; k < ALPHA_CHARS; k++) begin
      if (k < span) begin
        do pick = 8'($urandom); while (taken[pick]);
        taken[pick] = 1'b1;
        digits[k] = pick;
      end else begin
        digits[k] = 8'($urandom);
      end
    end
    case (flaw)
      FLAW_PLUS:  digits[$urandom_range(0, span - 1)] = CHAR_PLUS;
      FLAW_MINUS: digits[$urandom_range(0, span - 1)] = CHAR_MINUS;
      FLAW_REPEAT: begin
        if (span >= 3) begin
          i = $urandom_range(0, span - 3);
          j = $urandom_range(i + 2, span - 1);
        end else begin
          i = 0;
          j = 1;
        end
        digits[j] = digits[i];
      end
      default: ;
    endcase
    return digits;
  endfunction

  function automatic logic [NUMBER_W-1:0] random_number();
    logic [NUMBER_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 1100);
      6: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, {(NUMBER_W-1){1'b0}}};
          default: v = {1'b0, {(NUMBER_W-1){1'b1}}};
        endcase
      end
      default: v = $urandom >> $urandom_range(0, NUMBER_W - 1);
    endcase
    if ($urandom_range(0, 1) == 1 && v != {1'b1, {(NUMBER_W-1){1'b0}}})
      v = ~v + 1'b1;
    return v;
  endfunction

  initial begin
    alpha_t      digits;
    string       hex_digits;
    int          len;
    alpha_flaw_t flaw;
    int          bad_len[7];
    alpha_flaw_t bad_flaw[7];

    sb = new();
    hex_digits = "0123456789abcdef";
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decimal digits out of reset
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(10);
    send_number(-10);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    wait_for_results();

    // binary: longest outputs
    digits = build_alphabet(2, FLAW_NONE, 1'b0);
    digits[0] = "0";
    digits[1] = "1";
    apply_config(2, digits, 1'b0);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(-1);
    wait_for_results();

    // radix 32 with a NUL byte as the zero digit
    apply_config(ALPHA_CHARS, build_alphabet(ALPHA_CHARS, FLAW_NONE, 1'b1), 1'b0);
    send_number(0);
    send_number(31);
    send_number(-32);
    send_number(32'h8000_0000);
    wait_for_results();

    // invalid alphabets: short, long, sign characters, distant repeat
    bad_len = '{0, 1, 33, 63, 10, 12, 32};
    bad_flaw = '{FLAW_NONE, FLAW_NONE, FLAW_NONE, FLAW_NONE, FLAW_PLUS, FLAW_MINUS,
                 FLAW_REPEAT};
    for (int b = 0; b < 7; b++) begin
      apply_config(bad_len[b], build_alphabet(bad_len[b], bad_flaw[b], 1'b0), 1'b0);
      send_number(random_number());
      wait_for_results();
    end

    // hex, followed by a write to an unused index that must change nothing
    digits = build_alphabet(16, FLAW_NONE, 1'b0);
    for (int k = 0; k < 16; k++)
      digits[k] = hex_digits[k];
    apply_config(16, digits, 1'b1);
    send_number(255);
    send_number(-256);
    wait_for_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gaps_on = (p != 4);
      flaw = FLAW_NONE;
      case ($urandom_range(0, 9))
        0, 1:       len = 2;
        2, 3:       len = MAX_RADIX;
        4, 5, 6, 7: len = $urandom_range(3, MAX_RADIX - 1);
        8: begin
          case ($urandom_range(0, 2))
            0: len = 0;
            1: len = 1;
            default: len = $urandom_range(MAX_RADIX + 1, (1 << LEN_W) - 1);
          endcase
        end
        default: begin
          len = $urandom_range(MIN_RADIX, MAX_RADIX);
          flaw = alpha_flaw_t'($urandom_range(int'(FLAW_PLUS), int'(FLAW_REPEAT)));
        end
      endcase
      apply_config(len, build_alphabet(len, flaw, $urandom_range(0, 3) == 0),
                   $urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_number(random_number());
        if ((p == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 19) == 0)
          wait_for_results();
      end
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d numbers, %0d output transactions (%0d error results), %0d settings",
             sb.numbers_seen, sb.chars_seen, sb.errors_seen, settings_applied);
    $display("Covered radix 2 to 32, NUL digit, extreme values, bad alphabets, unused index");
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: signed_integer_to_radix_text.f
+incdir+rtl/core
rtl/core/sitr_pkg.sv
rtl/core/sitr_ram.sv
rtl/core/sitr_ctrl.sv
rtl/core/sitr_dp.sv
rtl/core/signed_integer_to_radix_text.sv
sim/testbench.sv
